FILE: design/eum_pkg.sv
// Package with shared types, constants and the CORDIC angle table.
`timescale 1ns / 1ps
package eum_pkg;
	localparam int CORDIC_STEPS = 16;
	localparam int ANGLE_BITS = 16;
	localparam int NSTEP = (CORDIC_STEPS < 30) ? CORDIC_STEPS : 30;
	localparam int SW = $clog2(NSTEP + 1);
	localparam logic signed [33:0] GAIN = 34'sd652032874;
	localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;
	localparam logic [2:0] REG_PAX = 3'd0;
	localparam logic [2:0] REG_PAY = 3'd1;
	localparam logic [2:0] REG_PAZ = 3'd2;
	localparam logic [2:0] REG_PPX = 3'd3;
	localparam logic [2:0] REG_PPY = 3'd4;
	localparam logic [2:0] REG_PPZ = 3'd5;
	localparam int QDEPTH = 2;

	typedef struct packed {
		logic [31:0] ax;
		logic [31:0] ay;
		logic [31:0] az;
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic signed [31:0] sz;
		logic signed [31:0] tx;
		logic signed [31:0] ty;
		logic signed [31:0] tz;
	} job_t;

	function automatic logic signed [33:0] atan_of(input logic [4:0] i);
		logic signed [33:0] r;
		begin
			unique case (i)
				5'd0: r = 34'sd536870912;  5'd1: r = 34'sd316933406;
				5'd2: r = 34'sd167458907;  5'd3: r = 34'sd85004756;
				5'd4: r = 34'sd42667331;   5'd5: r = 34'sd21354465;
				5'd6: r = 34'sd10679838;   5'd7: r = 34'sd5340245;
				5'd8: r = 34'sd2670163;    5'd9: r = 34'sd1335087;
				5'd10: r = 34'sd667544;    5'd11: r = 34'sd333772;
				5'd12: r = 34'sd166886;    5'd13: r = 34'sd83443;
				5'd14: r = 34'sd41722;     5'd15: r = 34'sd20861;
				5'd16: r = 34'sd10430;     5'd17: r = 34'sd5215;
				5'd18: r = 34'sd2608;      5'd19: r = 34'sd1304;
				5'd20: r = 34'sd652;       5'd21: r = 34'sd326;
				5'd22: r = 34'sd163;       5'd23: r = 34'sd81;
				5'd24: r = 34'sd41;        5'd25: r = 34'sd20;
				5'd26: r = 34'sd10;        5'd27: r = 34'sd5;
				5'd28: r = 34'sd3;         5'd29: r = 34'sd1;
				default: r = 34'sd0;
			endcase
			return r;
		end
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		begin
			if (v > 66'sd2147483647) return 32'sh7fff_ffff;
			else if (v < -66'sd2147483648) return 32'sh8000_0000;
			else return v[31:0];
		end
	endfunction
endpackage

FILE: design/eum_front.sv
// Front end: input acceptance, parent transform add and angle widening.
`timescale 1ns / 1ps
module eum_front import eum_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic mode,
	input  logic [15:0] ax_in,
	input  logic [15:0] ay_in,
	input  logic [15:0] az_in,
	input  logic signed [31:0] sx_in,
	input  logic signed [31:0] sy_in,
	input  logic signed [31:0] sz_in,
	input  logic signed [31:0] px_in,
	input  logic signed [31:0] py_in,
	input  logic signed [31:0] pz_in,
	output logic job_valid,
	input  logic job_ready,
	output job_t job
);
	logic [15:0] pax_q, pay_q, paz_q;
	logic signed [31:0] ppx_q, ppy_q, ppz_q;
	job_t job_q;
	logic valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pax_q <= '0; pay_q <= '0; paz_q <= '0;
			ppx_q <= '0; ppy_q <= '0; ppz_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PAX: pax_q <= cfg_data[15:0];
				REG_PAY: pay_q <= cfg_data[15:0];
				REG_PAZ: paz_q <= cfg_data[15:0];
				REG_PPX: ppx_q <= cfg_data;
				REG_PPY: ppy_q <= cfg_data;
				REG_PPZ: ppz_q <= cfg_data;
				default: ;
			endcase
		end
	end

	function automatic logic [31:0] widen(input logic [15:0] a);
		logic [ANGLE_BITS-1:0] m;
		begin
			m = ANGLE_BITS'({16'd0, a});
			return 32'({m, {(32 - ANGLE_BITS){1'b0}}});
		end
	endfunction

	function automatic logic signed [31:0] padd(input logic signed [31:0] a,
			input logic signed [31:0] b);
		begin
			return sat32(66'(a) + 66'(b));
		end
	endfunction

	assign in_ready = !valid_q || job_ready;
	assign job_valid = valid_q;
	assign job = job_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (in_ready) valid_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			job_q.ax <= widen(mode ? ax_in + pax_q : ax_in);
			job_q.ay <= widen(mode ? ay_in + pay_q : ay_in);
			job_q.az <= widen(mode ? az_in + paz_q : az_in);
			job_q.sx <= sx_in; job_q.sy <= sy_in; job_q.sz <= sz_in;
			job_q.tx <= mode ? padd(px_in, ppx_q) : px_in;
			job_q.ty <= mode ? padd(py_in, ppy_q) : py_in;
			job_q.tz <= mode ? padd(pz_in, ppz_q) : pz_in;
		end
	end
endmodule

FILE: design/eum_queue.sv
// Short job queue between front and back ends.
`timescale 1ns / 1ps
module eum_queue import eum_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  job_t wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output job_t rd_data
);
	job_t mem_q [QDEPTH];
	logic [$clog2(QDEPTH)-1:0] wp_q, rp_q;
	logic [$clog2(QDEPTH+1)-1:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != ($clog2(QDEPTH+1))'(QDEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			if (wr && !rd) cnt_q <= cnt_q + 1'b1;
			else if (rd && !wr) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end
endmodule

FILE: design/eum_back.sv
// Back end: three CORDIC lanes, product sequencer and row output register.
`timescale 1ns / 1ps
module eum_back import eum_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	output logic job_ready,
	input  job_t job,
	output logic out_valid,
	input  logic out_ready,
	output logic [1:0] row_q_o,
	output logic signed [31:0] c0_o,
	output logic signed [31:0] c1_o,
	output logic signed [31:0] c2_o,
	output logic signed [31:0] c3_o
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ROT = 2'd1;
	localparam logic [1:0] ST_MUL = 2'd2;
	localparam logic [1:0] ST_ROW = 2'd3;

	logic [1:0] st_q;
	logic [SW-1:0] it_q;
	logic [3:0] ph_q;
	logic [1:0] row_q;
	logic signed [33:0] x_q [3], y_q [3], z_q [3];
	logic neg_q [3];
	logic signed [31:0] sc_q [3], t_q [3];
	logic signed [33:0] s_q [3], c_q [3];
	logic signed [33:0] p_q [8];
	logic signed [33:0] a_q [9];
	logic ov_q;
	logic [1:0] orow_q;
	logic signed [31:0] oc_q [4];

	function automatic logic signed [33:0] m30(input logic signed [33:0] a,
			input logic signed [33:0] b);
		logic signed [67:0] p;
		begin
			p = 68'(a) * 68'(b);
			return 34'(p >>> 30);
		end
	endfunction

	function automatic logic signed [31:0] el(input logic signed [31:0] s,
			input logic signed [33:0] a);
		logic signed [65:0] p;
		begin
			p = 66'(s) * 66'(a);
			return sat32(p >>> 30);
		end
	endfunction

	assign job_ready = st_q == ST_IDLE;
	assign out_valid = ov_q;
	assign row_q_o = orow_q;
	assign c0_o = oc_q[0];
	assign c1_o = oc_q[1];
	assign c2_o = oc_q[2];
	assign c3_o = oc_q[3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; it_q <= '0; ph_q <= '0; row_q <= '0; ov_q <= 1'b0;
		end else begin
			if (st_q == ST_ROW && (!ov_q || out_ready)) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (job_valid) begin
					st_q <= ST_ROT; it_q <= '0;
				end
				ST_ROT: begin
					it_q <= it_q + 1'b1;
					if (it_q == SW'(NSTEP - 1)) begin
						st_q <= ST_MUL; ph_q <= '0;
					end
				end
				ST_MUL: begin
					ph_q <= ph_q + 1'b1;
					if (ph_q == 4'd2) begin
						st_q <= ST_ROW; row_q <= '0;
					end
				end
				ST_ROW: if (!ov_q || out_ready) begin
					row_q <= row_q + 1'b1;
					if (row_q == 2'd3) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				logic signed [33:0] z;
				logic [31:0] ang [3];
				ang[0] = job.ax; ang[1] = job.ay; ang[2] = job.az;
				sc_q[0] <= job.sx; sc_q[1] <= job.sy; sc_q[2] <= job.sz;
				t_q[0] <= job.tx; t_q[1] <= job.ty; t_q[2] <= job.tz;
				for (int k = 0; k < 3; k++) begin
					z = 34'(signed'(ang[k]));
					x_q[k] <= GAIN; y_q[k] <= '0; neg_q[k] <= 1'b0;
					if (z > 34'sd1073741824) begin
						z = z - 34'sd2147483648; neg_q[k] <= 1'b1;
					end else if (z < -34'sd1073741824) begin
						z = z + 34'sd2147483648; neg_q[k] <= 1'b1;
					end
					z_q[k] <= z;
				end
			end
			ST_ROT: begin
				for (int k = 0; k < 3; k++) begin
					if (!z_q[k][33]) begin
						x_q[k] <= x_q[k] - (y_q[k] >>> it_q);
						y_q[k] <= y_q[k] + (x_q[k] >>> it_q);
						z_q[k] <= z_q[k] - atan_of(5'(it_q));
					end else begin
						x_q[k] <= x_q[k] + (y_q[k] >>> it_q);
						y_q[k] <= y_q[k] - (x_q[k] >>> it_q);
						z_q[k] <= z_q[k] + atan_of(5'(it_q));
					end
				end
				if (it_q == SW'(NSTEP - 1)) begin
					for (int k = 0; k < 3; k++) begin
						logic signed [33:0] xn, yn;
						if (!z_q[k][33]) begin
							xn = x_q[k] - (y_q[k] >>> it_q);
							yn = y_q[k] + (x_q[k] >>> it_q);
						end else begin
							xn = x_q[k] + (y_q[k] >>> it_q);
							yn = y_q[k] - (x_q[k] >>> it_q);
						end
						c_q[k] <= neg_q[k] ? -xn : xn;
						s_q[k] <= neg_q[k] ? -yn : yn;
					end
				end
			end
			ST_MUL: begin
				// Lane 0 is phi, lane 1 theta, lane 2 psi.
				if (ph_q == 4'd0) begin
					p_q[0] <= m30(c_q[1], s_q[0]);
					p_q[1] <= m30(c_q[1], c_q[0]);
					p_q[2] <= m30(c_q[2], c_q[0]);
					p_q[3] <= m30(c_q[2], s_q[0]);
					p_q[4] <= m30(s_q[2], c_q[0]);
					p_q[5] <= m30(s_q[2], s_q[0]);
					a_q[2] <= m30(s_q[2], s_q[1]);
					a_q[5] <= -m30(c_q[2], s_q[1]);
					a_q[6] <= m30(s_q[1], s_q[0]);
					a_q[7] <= m30(s_q[1], c_q[0]);
					a_q[8] <= c_q[1];
				end else if (ph_q == 4'd1) begin
					p_q[6] <= m30(s_q[2], p_q[0]);
					p_q[7] <= m30(s_q[2], p_q[1]);
					a_q[3] <= m30(c_q[2], p_q[0]);
					a_q[4] <= m30(c_q[2], p_q[1]);
				end else begin
					a_q[0] <= p_q[2] - p_q[6];
					a_q[1] <= -p_q[3] - p_q[7];
					a_q[3] <= p_q[4] + a_q[3];
					a_q[4] <= -p_q[5] + a_q[4];
				end
			end
			ST_ROW: if (!ov_q || out_ready) begin
				orow_q <= row_q;
				if (row_q == 2'd3) begin
					oc_q[0] <= '0; oc_q[1] <= '0; oc_q[2] <= '0; oc_q[3] <= ONE_Q16;
				end else begin
					for (int k = 0; k < 3; k++)
						oc_q[k] <= el(sc_q[k], a_q[row_q * 3 + k]);
					oc_q[3] <= t_q[row_q];
				end
			end
			default: ;
		endcase
	end
endmodule

FILE: design/euler_model_matrix.sv
// Top level of the Euler angle model matrix block.
// Each input beat yields four output beats, rows 0..3 of a row-major 4x4 model matrix
// (ZXZ rotation times per-column scale, position in column 3), tlast on row 3. The back
// end iterates sine/cosine for all three angles in parallel CORDIC lanes, then forms the
// rotation products and the four rows, holding the item until its last row is loaded for output.
// The front end and a two-entry queue accept following items meanwhile. Parent registers apply
// in child mode; the user must write them only while the block is idle (not enforced).
`timescale 1ns / 1ps
module euler_model_matrix import eum_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  logic s_tvalid,
	output logic s_tready,
	// mode[0], angle_x[16:1], angle_y[32:17], angle_z[48:33], scale_x[80:49],
	// scale_y[112:81], scale_z[144:113], pos_x[176:145], pos_y[208:177], pos_z[240:209]
	input  logic [247:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// row_index[1:0], col0[33:2], col1[65:34], col2[97:66], col3[129:98]
	output logic [135:0] m_tdata,
	output logic m_tlast
);
	logic fv, fr, bv, br;
	job_t fj, bj;
	logic [1:0] row;
	logic signed [31:0] c0, c1, c2, c3;

	eum_front u_front (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid(s_tvalid), .in_ready(s_tready), .mode(s_tdata[0]),
		.ax_in(s_tdata[16:1]), .ay_in(s_tdata[32:17]), .az_in(s_tdata[48:33]),
		.sx_in(s_tdata[80:49]), .sy_in(s_tdata[112:81]), .sz_in(s_tdata[144:113]),
		.px_in(s_tdata[176:145]), .py_in(s_tdata[208:177]), .pz_in(s_tdata[240:209]),
		.job_valid(fv), .job_ready(fr), .job(fj)
	);

	eum_queue u_queue (
		.clk, .arst_n, .wr_valid(fv), .wr_ready(fr), .wr_data(fj),
		.rd_valid(bv), .rd_ready(br), .rd_data(bj)
	);

	eum_back u_back (
		.clk, .arst_n, .job_valid(bv), .job_ready(br), .job(bj),
		.out_valid(m_tvalid), .out_ready(m_tready), .row_q_o(row),
		.c0_o(c0), .c1_o(c1), .c2_o(c2), .c3_o(c3)
	);

	assign m_tdata = {6'd0, c3, c2, c1, c0, row};
	assign m_tlast = row == 2'd3;
endmodule

FILE: design/eum_checker.sv
// Port-level checker for the model matrix block, bound to the top level.
`timescale 1ns / 1ps
module eum_checker (
	input logic clk,
	input logic arst_n,
	input logic m_tvalid,
	input logic m_tready,
	input logic [135:0] m_tdata,
	input logic m_tlast
);
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tdata[1:0] == 2'd3)))
		else $error("tlast does not match row 3");
	a_row3: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tdata[129:2] == {32'h0001_0000, 96'd0}))
		else $error("row 3 is not 0,0,0,1");
	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) ##1 m_tvalid |->
		(m_tdata[1:0] == $past(m_tdata[1:0]) + 2'd1))
		else $error("row order broken");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled beat changed");
endmodule

bind euler_model_matrix eum_checker u_eum_checker (
	.clk, .arst_n, .m_tvalid, .m_tready, .m_tdata, .m_tlast
);
